[rtl/ssde_pkg.sv]
// Shared types and constants of the shot speed drop estimator.
package ssde_pkg;

    localparam int START_MIN_W = 17;
    localparam int CFG_W       = 16;
    localparam int SHOT_W      = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_SUM_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DROP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_GAIN     = 2'd3;

    localparam logic [START_MIN_W-1:0] START_SUM_MIN_RST = 17'd0;
    localparam logic [CFG_W-1:0]       TRIGGER_DROP_RST  = 16'd100;
    localparam logic [CFG_W-1:0]       WINDOW_TICKS_RST  = 16'd10;
    localparam logic [CFG_W-1:0]       DROP_GAIN_RST     = 16'd0;
    localparam logic [CFG_W-1:0]       ONE_TICK          = 16'd1;

    // Half of one Q16 unit, added before the shift for round-half-up.
    localparam logic [16:0]         ROUND_HALF = 17'd32768;
    localparam logic [SHOT_W-1:0]   SHOT_MAX   = 16'hFFFF;

    // Per-transaction control that the window logic hands to each wheel lane.
    typedef struct packed {
        logic accept;
        logic running;
        logic was_running;
        logic arm;
        logic track;
    } lane_ctrl_t;

    // Flags that travel with a transaction through the scaling pipeline.
    typedef struct packed {
        logic done;
        logic open;
    } pipe_flags_t;

endpackage

[rtl/ssde_lane.sv]
// One wheel lane: previous speed, drop detection and running minimum.
module ssde_lane #(
    parameter int SPEED_BITS = 16
) (
    input  logic                         aclk,
    input  ssde_pkg::lane_ctrl_t         ctrl,
    input  logic signed [SPEED_BITS-1:0] cur_speed,
    input  logic [ssde_pkg::CFG_W-1:0]   trigger_drop,
    output logic signed [SPEED_BITS-1:0] last_eff,
    output logic                         fell,
    output logic signed [SPEED_BITS-1:0] min_next
);

    localparam int TW = (SPEED_BITS + 1 > ssde_pkg::CFG_W + 1) ?
                        SPEED_BITS + 1 : ssde_pkg::CFG_W + 1;

    logic signed [SPEED_BITS-1:0] last_speed_reg;
    logic signed [SPEED_BITS-1:0] min_speed_reg;
    logic signed [SPEED_BITS-1:0] min_cand;
    logic signed [TW-1:0]         diff_w;
    logic signed [TW-1:0]         trig_w;

    // On the first running tick the history is taken from the current speed.
    assign last_eff = ctrl.was_running ? last_speed_reg : cur_speed;
    assign diff_w   = TW'(last_eff) - TW'(cur_speed);
    assign trig_w   = TW'({1'b0, trigger_drop});
    assign fell     = (diff_w >= trig_w);

    assign min_cand = ctrl.arm ? cur_speed : min_speed_reg;
    assign min_next = (cur_speed < min_cand) ? cur_speed : min_cand;

    always_ff @(posedge aclk) begin
        if (ctrl.accept && ctrl.running) begin
            last_speed_reg <= cur_speed;
            if (ctrl.track) begin
                min_speed_reg <= min_next;
            end
        end
    end

endmodule

[rtl/ssde_scale.sv]
// Pipeline that turns a closed window's speed drop into the held estimate.
module ssde_scale #(
    parameter int SPEED_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ssde_pkg::pipe_flags_t           s_flags,
    input  logic signed [SPEED_BITS-1:0]    s_min_a,
    input  logic signed [SPEED_BITS-1:0]    s_min_b,
    input  logic signed [SPEED_BITS-1:0]    s_min_c,
    input  logic signed [SPEED_BITS+1:0]    s_start_sum,
    input  logic [ssde_pkg::CFG_W-1:0]      drop_gain,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ssde_pkg::pipe_flags_t           m_flags,
    output logic [ssde_pkg::SHOT_W-1:0]     m_shot_speed
);

    localparam int DW  = SPEED_BITS + 2;
    localparam int DFW = SPEED_BITS + 3;
    localparam int PW  = DW + ssde_pkg::CFG_W;
    localparam int EW  = (DW + 1 > 17) ? DW + 1 : 17;

    // Stage 1: captured minima and start sum.
    logic                         p1_valid_reg;
    ssde_pkg::pipe_flags_t        p1_flags_reg;
    logic signed [SPEED_BITS-1:0] p1_min_a_reg, p1_min_b_reg, p1_min_c_reg;
    logic signed [DW-1:0]         p1_start_reg;
    // Stage 2: clamped drop.
    logic                         p2_valid_reg;
    ssde_pkg::pipe_flags_t        p2_flags_reg;
    logic [DW-1:0]                p2_drop_reg;
    // Stage 3: product with the gain.
    logic                         p3_valid_reg;
    ssde_pkg::pipe_flags_t        p3_flags_reg;
    logic [PW-1:0]                p3_prod_reg;
    // Output stage.
    logic                         out_valid_reg;
    ssde_pkg::pipe_flags_t        out_flags_reg;
    logic [ssde_pkg::SHOT_W-1:0]  held_estimate_reg;
    logic [ssde_pkg::SHOT_W-1:0]  held_estimate_next;

    logic p1_ready, p2_ready, p3_ready, out_ready;

    logic signed [DFW-1:0]        drop_full;
    logic [DW-1:0]                drop_clamped;
    logic [PW:0]                  rounded;
    logic [EW-1:0]                scaled_ext;
    logic [ssde_pkg::SHOT_W-1:0]  sat_value;

    assign out_ready = !out_valid_reg || m_ready;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_ready   = p1_ready;

    assign drop_full = DFW'(p1_start_reg) - DFW'(p1_min_a_reg)
                     - DFW'(p1_min_b_reg) - DFW'(p1_min_c_reg);
    assign drop_clamped = drop_full[DFW-1] ? '0 : drop_full[DW-1:0];

    assign rounded    = (PW+1)'(p3_prod_reg) + (PW+1)'(ssde_pkg::ROUND_HALF);
    assign scaled_ext = EW'(rounded[PW:16]);
    assign sat_value  = (|scaled_ext[EW-1:16]) ? ssde_pkg::SHOT_MAX : scaled_ext[15:0];

    assign held_estimate_next = p3_flags_reg.done ? sat_value : held_estimate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            p3_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            held_estimate_reg <= '0;
        end else begin
            if (p1_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= p3_valid_reg;
                if (p3_valid_reg) begin
                    held_estimate_reg <= held_estimate_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready) begin
            p1_flags_reg <= s_flags;
            p1_min_a_reg <= s_min_a;
            p1_min_b_reg <= s_min_b;
            p1_min_c_reg <= s_min_c;
            p1_start_reg <= s_start_sum;
        end
        if (p2_ready) begin
            p2_flags_reg <= p1_flags_reg;
            p2_drop_reg  <= drop_clamped;
        end
        if (p3_ready) begin
            p3_flags_reg <= p2_flags_reg;
            p3_prod_reg  <= PW'(p2_drop_reg) * PW'(drop_gain);
        end
        if (out_ready) begin
            out_flags_reg <= p3_flags_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_flags      = out_flags_reg;
    assign m_shot_speed = held_estimate_reg;

endmodule

[rtl/shot_speed_drop_estimator_top.sv]
// Throughput: one transaction per cycle; the window state is updated in the
// accept cycle, and the drop, gain multiply and saturation follow in a
// 4-stage pipeline that stalls only when the result side holds back ready.
// Reset (aresetn low, synchronous) clears the window, history and estimate and
// loads the register defaults; the block accepts transactions right after it.
module shot_speed_drop_estimator_top #(
    parameter int SPEED_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [ssde_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ssde_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Input channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_running,
    input  logic signed [SPEED_BITS-1:0]          s_speed_a,
    input  logic signed [SPEED_BITS-1:0]          s_speed_b,
    input  logic signed [SPEED_BITS-1:0]          s_speed_c,
    // Result channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_estimate_done,
    output logic [ssde_pkg::SHOT_W-1:0]           m_shot_speed,
    output logic                                  m_window_open
);

    // Width that holds the sum of three speeds as well as the 17-bit threshold.
    localparam int SW = SPEED_BITS + 2;
    localparam int CW = (SW > ssde_pkg::START_MIN_W + 1) ? SW : ssde_pkg::START_MIN_W + 1;

    // Configuration registers.
    logic [ssde_pkg::START_MIN_W-1:0] start_sum_min_reg;
    logic [ssde_pkg::CFG_W-1:0]       trigger_drop_reg;
    logic [ssde_pkg::CFG_W-1:0]       window_ticks_reg;
    logic [ssde_pkg::CFG_W-1:0]       drop_gain_reg;

    // Window state.
    logic                     was_running_reg, was_running_next;
    logic                     window_active_reg, window_active_next;
    logic [ssde_pkg::CFG_W-1:0] ticks_left_reg, ticks_left_next;
    logic signed [SW-1:0]     start_sum_reg, start_sum_next;

    logic                     accept;
    logic                     arm;
    logic                     active_eff;
    logic                     close;
    logic                     done;
    logic [ssde_pkg::CFG_W-1:0] ticks_eff;
    logic [ssde_pkg::CFG_W-1:0] ticks_dec;
    logic signed [CW-1:0]     prev_sum;
    logic signed [CW-1:0]     sum_min_w;
    ssde_pkg::lane_ctrl_t     lane_ctrl;
    ssde_pkg::pipe_flags_t    pipe_flags;
    ssde_pkg::pipe_flags_t    out_flags;

    logic signed [SPEED_BITS-1:0] last_a, last_b, last_c;
    logic signed [SPEED_BITS-1:0] min_a, min_b, min_c;
    logic                         fell_a, fell_b, fell_c;

    assign accept = s_valid && s_ready;

    // Configuration writes must arrive only while idle; the block does not check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_sum_min_reg <= ssde_pkg::START_SUM_MIN_RST;
            trigger_drop_reg  <= ssde_pkg::TRIGGER_DROP_RST;
            window_ticks_reg  <= ssde_pkg::WINDOW_TICKS_RST;
            drop_gain_reg     <= ssde_pkg::DROP_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssde_pkg::REG_START_SUM_MIN: start_sum_min_reg <= cfg_wdata;
                ssde_pkg::REG_TRIGGER_DROP:  trigger_drop_reg  <= cfg_wdata[ssde_pkg::CFG_W-1:0];
                ssde_pkg::REG_WINDOW_TICKS:  window_ticks_reg  <= cfg_wdata[ssde_pkg::CFG_W-1:0];
                ssde_pkg::REG_DROP_GAIN:     drop_gain_reg     <= cfg_wdata[ssde_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Three wheel lanes work side by side; the logic below merges their flags
    // and speeds into one window decision.
    assign lane_ctrl.accept      = accept;
    assign lane_ctrl.running     = s_running;
    assign lane_ctrl.was_running = was_running_reg;
    assign lane_ctrl.arm         = arm;
    assign lane_ctrl.track       = active_eff;

    ssde_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_a (
        .aclk(aclk), .ctrl(lane_ctrl), .cur_speed(s_speed_a),
        .trigger_drop(trigger_drop_reg), .last_eff(last_a), .fell(fell_a), .min_next(min_a)
    );
    ssde_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_b (
        .aclk(aclk), .ctrl(lane_ctrl), .cur_speed(s_speed_b),
        .trigger_drop(trigger_drop_reg), .last_eff(last_b), .fell(fell_b), .min_next(min_b)
    );
    ssde_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_c (
        .aclk(aclk), .ctrl(lane_ctrl), .cur_speed(s_speed_c),
        .trigger_drop(trigger_drop_reg), .last_eff(last_c), .fell(fell_c), .min_next(min_c)
    );

    // The previous-speed sum must reach the threshold; a negative sum never does.
    assign prev_sum  = CW'(last_a) + CW'(last_b) + CW'(last_c);
    assign sum_min_w = CW'({1'b0, start_sum_min_reg});

    assign arm = s_running && !window_active_reg && (prev_sum >= sum_min_w)
               && (fell_a || fell_b || fell_c);
    assign active_eff = s_running && (window_active_reg || arm);

    // A zero window length behaves as one tick.
    assign ticks_eff = arm ? ((window_ticks_reg == '0) ? ssde_pkg::ONE_TICK : window_ticks_reg)
                           : ticks_left_reg;
    assign ticks_dec = (ticks_eff != '0) ? ticks_eff - ssde_pkg::ONE_TICK : '0;
    assign close     = (ticks_dec == '0);
    assign done      = active_eff && close;

    always_comb begin
        was_running_next   = s_running;
        start_sum_next     = arm ? prev_sum[SW-1:0] : start_sum_reg;
        if (!s_running) begin
            window_active_next = 1'b0;
            ticks_left_next    = '0;
        end else if (active_eff) begin
            window_active_next = !close;
            ticks_left_next    = ticks_dec;
        end else begin
            window_active_next = 1'b0;
            ticks_left_next    = ticks_left_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_running_reg   <= 1'b0;
            window_active_reg <= 1'b0;
            ticks_left_reg    <= '0;
            start_sum_reg     <= '0;
        end else if (accept) begin
            was_running_reg   <= was_running_next;
            window_active_reg <= window_active_next;
            ticks_left_reg    <= ticks_left_next;
            start_sum_reg     <= start_sum_next;
        end
    end

    // The window outcome of each transaction enters the scaling pipeline, which
    // also holds the estimate between windows and parts input from output.
    assign pipe_flags.done = done;
    assign pipe_flags.open = window_active_next;

    ssde_scale #(.SPEED_BITS(SPEED_BITS)) u_scale (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_flags(pipe_flags),
        .s_min_a(min_a),
        .s_min_b(min_b),
        .s_min_c(min_c),
        .s_start_sum(start_sum_next),
        .drop_gain(drop_gain_reg),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_flags(out_flags),
        .m_shot_speed(m_shot_speed)
    );

    assign m_estimate_done = out_flags.done;
    assign m_window_open   = out_flags.open;

    // A finished window is never reported as still open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_estimate_done |-> !m_window_open)
        else $error("estimate reported done while window still open");

    // An open window always has ticks left to count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        window_active_reg |-> (ticks_left_reg != '0))
        else $error("window open with no ticks left");

    // A window can only be open while the wheels are running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        window_active_reg |-> was_running_reg)
        else $error("window open outside run");

    // A transaction without run closes the window and clears the run history.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_running |=> !window_active_reg && !was_running_reg
                                 && (ticks_left_reg == '0))
        else $error("stop transaction did not close the window");

endmodule

[tb/shot_speed_drop_estimator_top_tb.sv]
// Self-checking testbench for the shot speed drop estimator top level.
`timescale 1ns / 100ps

module shot_speed_drop_estimator_top_tb;

    localparam int          SPEED_BITS   = 16;
    // Results leave through the scaling pipeline, so a short settle is plenty.
    localparam int          SETTLE_TICKS = 16;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          REPORT_MAX   = 10;
    localparam int          IDLE_PCT     = 27;

    // One control tick as seen on the input channel.
    typedef struct {
        logic                         running;
        logic signed [SPEED_BITS-1:0] speed_a;
        logic signed [SPEED_BITS-1:0] speed_b;
        logic signed [SPEED_BITS-1:0] speed_c;
    } tick_t;

    // One transaction on the result channel.
    typedef struct {
        logic                        done;
        logic [ssde_pkg::SHOT_W-1:0] shot;
        logic                        open;
    } estimate_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            cfg_wr_en = 1'b0;
    logic [ssde_pkg::CFG_IDX_W-1:0]  cfg_index = ssde_pkg::REG_START_SUM_MIN;
    logic [ssde_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic                         s_running = 1'b0;
    logic signed [SPEED_BITS-1:0] s_speed_a = '0;
    logic signed [SPEED_BITS-1:0] s_speed_b = '0;
    logic signed [SPEED_BITS-1:0] s_speed_c = '0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_estimate_done;
    logic [ssde_pkg::SHOT_W-1:0]  m_shot_speed;
    logic                         m_window_open;

    shot_speed_drop_estimator_top #(
        .SPEED_BITS(SPEED_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_running      (s_running),
        .s_speed_a      (s_speed_a),
        .s_speed_b      (s_speed_b),
        .s_speed_c      (s_speed_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_estimate_done(m_estimate_done),
        .m_shot_speed   (m_shot_speed),
        .m_window_open  (m_window_open)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Register copies held by the testbench. They start at the reset defaults
    // and follow every write on the configuration port.
    logic [ssde_pkg::START_MIN_W-1:0] cfg_start_min = ssde_pkg::START_SUM_MIN_RST;
    logic [ssde_pkg::CFG_W-1:0]       cfg_trigger   = ssde_pkg::TRIGGER_DROP_RST;
    logic [ssde_pkg::CFG_W-1:0]       cfg_window    = ssde_pkg::WINDOW_TICKS_RST;
    logic [ssde_pkg::CFG_W-1:0]       cfg_gain      = ssde_pkg::DROP_GAIN_RST;

    // Window and history state of the estimator, all starting at zero.
    logic signed [SPEED_BITS-1:0] prev_speed [3] = '{default: '0};
    logic signed [SPEED_BITS-1:0] win_min    [3] = '{default: '0};
    logic                         seen_run      = 1'b0;
    logic                         win_armed     = 1'b0;
    logic [ssde_pkg::CFG_W-1:0]   win_left      = '0;
    logic signed [SPEED_BITS+1:0] win_start_sum = '0;
    logic [ssde_pkg::SHOT_W-1:0]  shot_held     = '0;

    // Estimates still owed by the block, oldest first.
    estimate_t   estimate_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    // While set, neither side inserts idle cycles.
    bit          steady_flow    = 1'b0;

    // Advances the estimator by one accepted tick and returns what the result
    // channel has to show for it. The arithmetic is done in 64 bits so that
    // sums of three speeds and the gain product can never wrap.
    function automatic estimate_t predict_estimate(input tick_t t);
        logic signed [SPEED_BITS-1:0] spd [3];
        longint    prev_sum;
        longint    drop;
        longint    scaled;
        logic      fell;
        estimate_t r;
        spd[0] = t.speed_a;
        spd[1] = t.speed_b;
        spd[2] = t.speed_c;
        r.done = 1'b0;
        if (!t.running) begin
            // Leaving run drops any open window but keeps the speed history.
            win_armed = 1'b0;
            win_left  = '0;
            seen_run  = 1'b0;
        end else begin
            // On the first running tick the history is seeded with the current
            // speeds, so that tick shows a drop only with a zero trigger.
            if (!seen_run) begin
                prev_speed = spd;
            end
            seen_run = 1'b1;
            if (!win_armed) begin
                prev_sum = longint'(prev_speed[0]) + longint'(prev_speed[1])
                         + longint'(prev_speed[2]);
                fell = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    if (longint'(prev_speed[i]) - longint'(spd[i])
                            >= longint'(cfg_trigger)) begin
                        fell = 1'b1;
                    end
                end
                // A negative history sum never reaches the unsigned threshold.
                if (prev_sum >= longint'(cfg_start_min) && fell) begin
                    win_armed     = 1'b1;
                    win_left      = (cfg_window == '0) ? ssde_pkg::ONE_TICK : cfg_window;
                    win_start_sum = prev_sum[SPEED_BITS+1:0];
                    win_min       = spd;
                end
            end
            if (win_armed) begin
                for (int i = 0; i < 3; i++) begin
                    if (spd[i] < win_min[i]) begin
                        win_min[i] = spd[i];
                    end
                end
                if (win_left != '0) begin
                    win_left = win_left - 1'b1;
                end
                if (win_left == '0) begin
                    drop = longint'(win_start_sum) - (longint'(win_min[0])
                         + longint'(win_min[1]) + longint'(win_min[2]));
                    if (drop < 0) begin
                        drop = 0;
                    end
                    // Round half up in Q16, then saturate to the output width.
                    scaled = (drop * longint'(cfg_gain)
                              + longint'(ssde_pkg::ROUND_HALF)) >>> 16;
                    shot_held = (scaled > longint'(ssde_pkg::SHOT_MAX)) ?
                                ssde_pkg::SHOT_MAX : scaled[ssde_pkg::SHOT_W-1:0];
                    win_armed = 1'b0;
                    r.done    = 1'b1;
                end
            end
            prev_speed = spd;
        end
        r.shot = shot_held;
        r.open = win_armed;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // Sends one tick as an input transaction and records its expected result
    // once it is accepted. A random gap with valid low may come first. Valid
    // is left high afterwards, so back-to-back transactions never lower it.
    task automatic send_tick(input bit run, input int a, input int b, input int c);
        tick_t t;
        t.running = run;
        t.speed_a = a[SPEED_BITS-1:0];
        t.speed_b = b[SPEED_BITS-1:0];
        t.speed_c = c[SPEED_BITS-1:0];
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid   <= 1'b1;
        s_running <= t.running;
        s_speed_a <= t.speed_a;
        s_speed_b <= t.speed_b;
        s_speed_c <= t.speed_c;
        do @(posedge aclk); while (!s_ready);
        estimate_q.push_back(predict_estimate(t));
    endtask

    // Lowers valid and waits until every owed result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (estimate_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes all four registers on consecutive cycles. The block must be
    // idle; the write enable is held high across the burst and dropped once.
    task automatic load_settings(input logic [ssde_pkg::START_MIN_W-1:0] start_min,
                                 input logic [ssde_pkg::CFG_W-1:0] trigger,
                                 input logic [ssde_pkg::CFG_W-1:0] window,
                                 input logic [ssde_pkg::CFG_W-1:0] gain);
        cfg_wr_en <= 1'b1;
        cfg_index <= ssde_pkg::REG_START_SUM_MIN;
        cfg_wdata <= start_min;
        @(posedge aclk);
        cfg_index <= ssde_pkg::REG_TRIGGER_DROP;
        cfg_wdata <= {1'b0, trigger};
        @(posedge aclk);
        cfg_index <= ssde_pkg::REG_WINDOW_TICKS;
        cfg_wdata <= {1'b0, window};
        @(posedge aclk);
        cfg_index <= ssde_pkg::REG_DROP_GAIN;
        cfg_wdata <= {1'b0, gain};
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        cfg_start_min  = start_min;
        cfg_trigger    = trigger;
        cfg_window     = window;
        cfg_gain       = gain;
    endtask

    // Reset register values: an idle tick at extreme speeds, entry into run,
    // a 100 rpm drop that opens a ten-tick window, then a stop that closes
    // the window without producing an estimate.
    task automatic test_reset_defaults();
        send_tick(1'b0, -32768, 32767, 0);
        send_tick(1'b1, 1000, 1000, 1000);
        send_tick(1'b1, 900, 1000, 1000);
        send_tick(1'b1, 950, 980, 1000);
        send_tick(1'b0, 0, 0, 0);
        wait_drained();
    endtask

    // Zero window length behaves as one tick: the window opens and closes on
    // the same transaction. Trigger at maximum and threshold at the largest
    // three-speed sum let a full-scale drop at the largest gain saturate the
    // estimate. A large drop after a too small history sum must not arm.
    task automatic test_single_tick_window();
        load_settings(17'd98301, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(1'b1, 32767, 32767, 32767);
        send_tick(1'b1, -32768, -32768, -32768);
        send_tick(1'b1, 32767, 32767, -32767);
        send_tick(1'b1, -32768, 32767, 32767);
        wait_drained();
    endtask

    // Zero threshold and zero trigger: a negative history sum still blocks
    // arming, a window whose minima rise above the start sum clamps to zero,
    // and a one rpm drop at half gain rounds up to one.
    task automatic test_rounding_and_clamp();
        load_settings(17'd0, 16'd0, 16'd2, 16'd32768);
        send_tick(1'b1, -10, -10, -10);
        send_tick(1'b1, -10, -10, -10);
        send_tick(1'b1, 5, 5, -10);
        send_tick(1'b1, 5, 5, 5);
        send_tick(1'b1, 3, 5, 5);
        send_tick(1'b1, 3, 5, 4);
        send_tick(1'b1, 3, 5, 4);
        wait_drained();
    endtask

    // The longest window stays open across several ticks and is dropped
    // by leaving run, so the held estimate must not change.
    task automatic test_open_window_abort();
        load_settings(17'd0, 16'd1, 16'hFFFF, 16'd1);
        send_tick(1'b1, 100, 100, 100);
        send_tick(1'b1, 99, 100, 100);
        send_tick(1'b1, 50, 40, 30);
        send_tick(1'b1, 60, 70, 80);
        send_tick(1'b0, 0, 0, 0);
        wait_drained();
    endtask

    // Random traffic under one random setting. Most of it is shot-like: a
    // steady run near one speed level, a drop on one wheel to at least the
    // trigger below that level, random dips while the window is open, and a
    // short stop. The rest is noise: random run flags and full-range speeds.
    task automatic test_random_traffic(input int unsigned n_items, input bit steady);
        int unsigned sent;
        int          base;
        int          trigger;
        int          window;
        int          start_min;
        int          gain;
        int          span;
        int          drop_at;
        int          spd [3];
        int unsigned wheel;
        sent      = 0;
        base      = $urandom_range(2000, 30000);
        trigger   = $urandom_range(0, 3000);
        window    = $urandom_range(1, 12);
        start_min = $urandom_range(0, 3 * base);
        gain      = $urandom_range(0, 65535);
        load_settings(start_min[ssde_pkg::START_MIN_W-1:0], trigger[ssde_pkg::CFG_W-1:0],
                      window[ssde_pkg::CFG_W-1:0], gain[ssde_pkg::CFG_W-1:0]);
        steady_flow = steady;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6)) begin
                    send_tick(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
                    sent++;
                end
            end else begin
                span    = window + $urandom_range(2, 10);
                drop_at = $urandom_range(1, 3);
                wheel   = $urandom_range(0, 2);
                for (int k = 0; k < span; k++) begin
                    for (int w = 0; w < 3; w++) begin
                        if (k > drop_at && k <= drop_at + window) begin
                            spd[w] = base - $urandom_range(0, 4000);
                        end else begin
                            spd[w] = base + $urandom_range(0, 100) - 50;
                        end
                    end
                    if (k == drop_at) begin
                        spd[wheel] = base - trigger - $urandom_range(0, 2000);
                    end
                    send_tick(1'b1, spd[0], spd[1], spd[2]);
                    sent++;
                end
                repeat ($urandom_range(0, 3)) begin
                    send_tick(1'b0, $urandom(), $urandom(), $urandom());
                    sent++;
                end
            end
        end
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // Result side: random back-pressure, and a field-by-field compare of each
    // accepted result transaction against the oldest expectation.
    always @(posedge aclk) begin : check_results
        estimate_t want;
        m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                note_failure($sformatf("unexpected result: done=%0b shot=%0d open=%0b",
                                       m_estimate_done, m_shot_speed, m_window_open));
            end else begin
                want = estimate_q.pop_front();
                if (m_estimate_done !== want.done || m_shot_speed !== want.shot
                        || m_window_open !== want.open) begin
                    note_failure($sformatf({"mismatch: expected done=%0b shot=%0d open=%0b,",
                                            " got done=%0b shot=%0d open=%0b"},
                        want.done, want.shot, want.open,
                        m_estimate_done, m_shot_speed, m_window_open));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // A hung handshake ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("shot_speed_drop_estimator_top_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_single_tick_window();
        test_rounding_and_clamp();
        test_open_window_abort();
        // The fourth phase runs without any idle cycles on either side.
        for (int p = 0; p < 8; p++) begin
            test_random_traffic(250, p == 3);
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatch_count == 0 && estimate_q.size() == 0) begin
            $display("shot_speed_drop_estimator_top_tb OK");
        end else begin
            $display("shot_speed_drop_estimator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
